// ===== rtl/fdx_pkg.sv =====
// ----------------------------------------------------------------------------
// fdx_pkg
// shared types and constants for the serial frame deframer core
// ----------------------------------------------------------------------------
package fdx_pkg;

  // parse phase of the frame deframer
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_CMD     = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_t;

  // frame end status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  // result kinds carried on tuser
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_HEADER = 3'd0;
  localparam logic [2:0] REG_INT8   = 3'd1;
  localparam logic [2:0] REG_TWIST  = 3'd2;
  localparam logic [2:0] REG_STRING = 3'd3;
  localparam logic [2:0] REG_ACK    = 3'd4;
  localparam logic [2:0] REG_NACK   = 3'd5;

  // fixed payload lengths
  localparam logic [7:0] LEN_INT8  = 8'd1;
  localparam logic [7:0] LEN_TWIST = 8'd12;

  // one result word, fields from the highest bit down
  typedef struct packed {
    logic [5:0] pad;
    status_t    frame_status;
    logic [7:0] payload_count;
    logic [7:0] command_code;
    logic [7:0] data_byte;
  } result_t;

endpackage

// ===== rtl/frame_deframer_xor_checksum_core.sv =====
// ----------------------------------------------------------------------------
// frame_deframer_xor_checksum_core
// serial byte stream deframer with command decode and xor checksum check
// ----------------------------------------------------------------------------
// Received bytes come in one word per cycle on the slave stream unless
// stalled. The core hunts for the header byte, takes the next byte as the
// command and decodes the payload length from it (one byte for int8, twelve
// for twist, none for ack and nack, and for the string command the byte after
// the command gives the length). Every payload byte is passed on as a data
// word (tuser 0) as it arrives. The byte after the payload is the checksum,
// compared against the xor of all frame bytes before it; it closes the frame
// with a frame end word (tuser 1) carrying the command, the length and the
// status. An unknown command gives a frame end word with status unknown at
// once and the core goes back to hunting. Throughput is one byte per cycle
// unless stalled: each byte is held in the input register while the parse
// state is updated in a single pass; its result goes to the output register,
// which stalls the input register only when it holds an untaken result and
// the byte waiting would produce another one. The user must write command
// codes and the header value through the config port only while the core is
// idle; the core does not enforce it. When several command registers hold the
// same code, int8 wins over twist, string, ack and nack in that order.
// ----------------------------------------------------------------------------
module frame_deframer_xor_checksum_core
  import fdx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // config write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // received byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] data_byte, [15:8] command_code,
                                      // [23:16] payload_count,
                                      // [25:24] frame_status, rest zero
  output logic        m_axis_tuser    // [0] result_kind
);

  // config registers
  logic [7:0] header_value;
  logic [7:0] code_int8;
  logic [7:0] code_twist;
  logic [7:0] code_string;
  logic [7:0] code_ack;
  logic [7:0] code_nack;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  // parse state
  phase_t     phase, phase_next;
  logic [7:0] current_command, current_command_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] running_xor, running_xor_next;

  // result register
  logic       out_valid;
  logic       out_kind;
  result_t    out_word;

  // single pass outputs
  logic       res_hit;
  logic       res_kind;
  result_t    res_word;
  logic       advance;
  logic [7:0] len_sel;
  logic [7:0] left_dec;

  // config writes, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      header_value <= 8'd170;
      code_int8    <= 8'd1;
      code_twist   <= 8'd2;
      code_string  <= 8'd3;
      code_ack     <= 8'd4;
      code_nack    <= 8'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADER: header_value <= cfg_data;
        REG_INT8:   code_int8    <= cfg_data;
        REG_TWIST:  code_twist   <= cfg_data;
        REG_STRING: code_string  <= cfg_data;
        REG_ACK:    code_ack     <= cfg_data;
        REG_NACK:   code_nack    <= cfg_data;
        default:    ;
      endcase
    end
  end

  // byte in the input register moves on unless it would overwrite a held result
  assign advance       = in_valid && (!res_hit || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  assign left_dec = bytes_left - 8'd1;

  // parse step for the byte in the input register
  always_comb begin
    phase_next           = phase;
    current_command_next = current_command;
    bytes_left_next      = bytes_left;
    frame_length_next    = frame_length;
    running_xor_next     = running_xor;
    res_hit              = 1'b0;
    res_kind             = KIND_DATA;
    res_word             = '0;
    len_sel              = 8'd0;

    case (phase)
      PH_CMD: begin
        current_command_next = in_byte;
        running_xor_next     = running_xor ^ in_byte;
        if (in_byte == code_int8 || in_byte == code_twist ||
            in_byte == code_ack || in_byte == code_nack) begin
          // fixed length command, int8 first, then twist
          if (in_byte == code_int8) begin
            len_sel = LEN_INT8;
          end else if (in_byte == code_twist) begin
            len_sel = LEN_TWIST;
          end else if (in_byte == code_string) begin
            len_sel = 8'd0;
          end else begin
            len_sel = 8'd0;
          end
          if (in_byte != code_int8 && in_byte != code_twist &&
              in_byte == code_string) begin
            phase_next = PH_LEN;
          end else begin
            frame_length_next = len_sel;
            bytes_left_next   = len_sel;
            phase_next        = (len_sel == 8'd0) ? PH_CHECK : PH_PAYLOAD;
          end
        end else if (in_byte == code_string) begin
          phase_next = PH_LEN;
        end else begin
          // unknown command, report now and hunt again
          frame_length_next     = 8'd0;
          bytes_left_next       = 8'd0;
          phase_next            = PH_HUNT;
          res_hit               = 1'b1;
          res_kind              = KIND_END;
          res_word.command_code = in_byte;
          res_word.frame_status = ST_UNKNOWN;
        end
      end
      PH_LEN: begin
        running_xor_next  = running_xor ^ in_byte;
        frame_length_next = in_byte;
        bytes_left_next   = in_byte;
        phase_next        = (in_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        running_xor_next      = running_xor ^ in_byte;
        bytes_left_next       = left_dec;
        if (left_dec == 8'd0) begin
          phase_next = PH_CHECK;
        end
        res_hit               = 1'b1;
        res_kind              = KIND_DATA;
        res_word.data_byte    = in_byte;
        res_word.command_code = current_command;
      end
      PH_CHECK: begin
        phase_next             = PH_HUNT;
        res_hit                = 1'b1;
        res_kind               = KIND_END;
        res_word.command_code  = current_command;
        res_word.payload_count = frame_length;
        res_word.frame_status  = (in_byte == running_xor) ? ST_OK : ST_BAD_SUM;
      end
      default: begin
        // hunting, unused codes land here too
        phase_next = PH_HUNT;
        if (in_byte == header_value) begin
          running_xor_next = in_byte;
          phase_next       = PH_CMD;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      current_command <= 8'd0;
      bytes_left      <= 8'd0;
      frame_length    <= 8'd0;
      running_xor     <= 8'd0;
    end else if (advance) begin
      phase           <= phase_next;
      current_command <= current_command_next;
      bytes_left      <= bytes_left_next;
      frame_length    <= frame_length_next;
      running_xor     <= running_xor_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_hit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_hit) begin
      out_kind <= res_kind;
      out_word <= res_word;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_word;
  assign m_axis_tuser  = out_kind;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // a data word never carries a length or a status
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_DATA) |->
      (m_axis_tdata[25:16] == 10'd0))
    else $error("data word with nonzero length or status");

  // payload phase always has bytes left to take
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (bytes_left != 8'd0))
    else $error("payload phase with no bytes left");

  // a held result is never overwritten while the sink stalls
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !(advance && res_hit))
    else $error("held result overwritten");

  // the input side only stalls behind a pending byte
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_valid && out_valid))
    else $error("input stalled with no pending byte");

endmodule

// ===== bench/fdx_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdx_result_checker
// watches the deframer ports, predicts every result word and compares it
// ----------------------------------------------------------------------------
// Keeps its own copy of the command registers and of the parse state, taken
// from the config port and the accepted input bytes. Each accepted result
// word is compared field by field with the oldest word still due.
// ----------------------------------------------------------------------------
module fdx_result_checker
  import fdx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        m_tuser,
  output int          fail_count,
  output int          due_count
);

  typedef struct packed {
    logic    kind;
    result_t word;
  } due_word_t;

  due_word_t due_words[$];

  logic [7:0] hdr_val, cmd_int8, cmd_twist, cmd_string, cmd_ack, cmd_nak;
  phase_t     ph;
  logic [7:0] cur_cmd, left, flen, xsum;

  initial begin
    fail_count = 0;
    due_count  = 0;
  end

  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] want);
    if (fail_count < 100)
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    case (idx)
      REG_HEADER: hdr_val    = val;
      REG_INT8:   cmd_int8   = val;
      REG_TWIST:  cmd_twist  = val;
      REG_STRING: cmd_string = val;
      REG_ACK:    cmd_ack    = val;
      REG_NACK:   cmd_nak    = val;
      default: ;
    endcase
  endtask

  task automatic start_payload(input logic [7:0] len);
    flen = len;
    left = len;
    ph   = (len == 8'd0) ? PH_CHECK : PH_PAYLOAD;
  endtask

  // one parse step per accepted byte, queues the word it causes if any
  task automatic parse_rx_byte(input logic [7:0] b);
    due_word_t d;
    logic      emit;
    d    = '0;
    emit = 1'b0;
    case (ph)
      PH_CMD: begin
        cur_cmd = b;
        xsum    = xsum ^ b;
        if (b == cmd_int8) start_payload(LEN_INT8);
        else if (b == cmd_twist) start_payload(LEN_TWIST);
        else if (b == cmd_string) ph = PH_LEN;
        else if (b == cmd_ack || b == cmd_nak) start_payload(8'd0);
        else begin
          flen = 8'd0;
          left = 8'd0;
          ph   = PH_HUNT;
          d.kind              = KIND_END;
          d.word.command_code = b;
          d.word.frame_status = ST_UNKNOWN;
          emit = 1'b1;
        end
      end
      PH_LEN: begin
        xsum = xsum ^ b;
        start_payload(b);
      end
      PH_PAYLOAD: begin
        xsum = xsum ^ b;
        left = left - 8'd1;
        if (left == 8'd0) ph = PH_CHECK;
        d.kind              = KIND_DATA;
        d.word.data_byte    = b;
        d.word.command_code = cur_cmd;
        emit = 1'b1;
      end
      PH_CHECK: begin
        ph = PH_HUNT;
        d.kind               = KIND_END;
        d.word.command_code  = cur_cmd;
        d.word.payload_count = flen;
        d.word.frame_status  = (b == xsum) ? ST_OK : ST_BAD_SUM;
        emit = 1'b1;
      end
      default: begin
        ph = PH_HUNT;
        if (b == hdr_val) begin
          xsum = b;
          ph   = PH_CMD;
        end
      end
    endcase
    if (emit) due_words.push_back(d);
  endtask

  task automatic check_word();
    result_t   got;
    due_word_t d;
    got = m_tdata;
    if (due_words.size() == 0) begin
      report("word with nothing due", m_tdata, 32'd0);
    end else begin
      d = due_words.pop_front();
      if (m_tuser != d.kind) report("result_kind", m_tuser, d.kind);
      if (got.data_byte != d.word.data_byte)
        report("data_byte", got.data_byte, d.word.data_byte);
      if (got.command_code != d.word.command_code)
        report("command_code", got.command_code, d.word.command_code);
      if (got.payload_count != d.word.payload_count)
        report("payload_count", got.payload_count, d.word.payload_count);
      if (got.frame_status != d.word.frame_status)
        report("frame_status", got.frame_status, d.word.frame_status);
      if (got.pad != '0) report("unused bits", got.pad, 32'd0);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      hdr_val    = 8'd170;
      cmd_int8   = 8'd1;
      cmd_twist  = 8'd2;
      cmd_string = 8'd3;
      cmd_ack    = 8'd4;
      cmd_nak    = 8'd5;
      ph         = PH_HUNT;
      cur_cmd    = 8'd0;
      left       = 8'd0;
      flen       = 8'd0;
      xsum       = 8'd0;
      due_words.delete();
    end else begin
      // outgoing word first: it can never stem from the byte taken now
      if (m_tvalid && m_tready) check_word();
      if (s_tvalid && s_tready) parse_rx_byte(s_tdata);
      if (cfg_we) write_reg(cfg_index, cfg_data);
    end
    due_count <= due_words.size();
  end

endmodule

// ===== bench/tb_frame_deframer_xor_checksum_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_deframer_xor_checksum_core
// stimulus and verdict for the serial frame deframer core
// ----------------------------------------------------------------------------
// Sends a short directed set of frames under the reset codes, then random
// frames, noise and broken frames under several code settings, with random
// gaps on both streams and one long receiver hold-off. A checker module
// beside the core predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_frame_deframer_xor_checksum_core;
  import fdx_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no word moving
  localparam int HOLD_CYCLES    = 200;   // long receiver hold-off
  localparam int PHASE_BYTES    = 260;   // random bytes per code setting
  localparam int SETTLE_CYCLES  = 6;     // input register drain before writes

  // all inputs known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [7:0]  cfg_data = 8'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;

  int fail_count;
  int due_count;

  // codes as last written, used to build well-formed frames
  logic [7:0] hdr = 8'd170;
  logic [7:0] c_int8 = 8'd1, c_twist = 8'd2, c_string = 8'd3;
  logic [7:0] c_ack = 8'd4, c_nack = 8'd5;

  logic [7:0] frame_q[$];   // frame body: command, length, payload
  int         sent_count = 0;
  bit         no_idle = 1'b0;
  bit         hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frame_deframer_xor_checksum_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  fdx_result_checker result_chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  // per-word wait, zero throughout a burst stretch
  function automatic int draw_gap();
    if (no_idle) draw_gap = 0;
    else draw_gap = $urandom_range(0, 19);
  endfunction

  // offer one byte and return at the edge it is taken; valid stays high
  // when the next byte follows with no gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_count++;
  endtask

  // header, frame_q, then the checksum unless the command was unknown
  task automatic send_frame_q(input bit add_sum, input bit bad_sum);
    logic [7:0] sum;
    sum = hdr;
    send_byte(hdr);
    foreach (frame_q[i]) begin
      sum = sum ^ frame_q[i];
      send_byte(frame_q[i]);
    end
    if (add_sum) send_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
  endtask

  // every register once, plus a write to an index past the list
  task automatic apply_config(input logic [7:0] h, input logic [7:0] i8,
                              input logic [7:0] tw, input logic [7:0] st,
                              input logic [7:0] ak, input logic [7:0] nk);
    logic [7:0] vals[6];
    vals = '{h, i8, tw, st, ak, nk};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_index <= 3'($urandom_range(6, 7));
    cfg_data  <= 8'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    hdr = h; c_int8 = i8; c_twist = tw; c_string = st; c_ack = ak; c_nack = nk;
  endtask

  // stop sending, let every due word drain, then let the input stage empty
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] payload_byte();
    // headers inside the payload now and then
    if ($urandom_range(0, 7) == 0) payload_byte = hdr;
    else payload_byte = 8'($urandom);
  endfunction

  task automatic send_random_frame();
    int         pick, len, n;
    logic [7:0] cmd;
    bit         has_len, known;
    pick    = $urandom_range(0, 99);
    no_idle = ($urandom_range(0, 3) == 0);
    has_len = 1'b0;
    known   = 1'b1;
    len     = 0;
    if (pick < 20) cmd = c_int8;
    else if (pick < 40) cmd = c_twist;
    else if (pick < 65) cmd = c_string;
    else if (pick < 75) cmd = c_ack;
    else if (pick < 85) cmd = c_nack;
    else if (pick < 92) begin
      known = 1'b0;
      do cmd = 8'($urandom);
      while (cmd == c_int8 || cmd == c_twist || cmd == c_string ||
             cmd == c_ack || cmd == c_nack);
    end else begin
      // noise or a frame cut short
      n = $urandom_range(1, 4);
      if ($urandom_range(0, 1) == 0) begin
        repeat (n) send_byte(8'($urandom));
      end else begin
        send_byte(hdr);
        send_byte(c_twist);
        repeat (n) send_byte(payload_byte());
      end
      return;
    end
    // payload length as the core decodes it, codes may overlap
    if (known) begin
      if (cmd == c_int8) len = 1;
      else if (cmd == c_twist) len = 12;
      else if (cmd == c_string) begin
        has_len = 1'b1;
        n = $urandom_range(0, 39);
        if (n == 0) len = 255;
        else if (n < 5) len = 0;
        else len = $urandom_range(1, 16);
      end else len = 0;
    end
    frame_q = {cmd};
    if (has_len) frame_q.push_back(8'(len));
    repeat (len) frame_q.push_back(payload_byte());
    send_frame_q(known, known && ($urandom_range(0, 9) == 0));
  endtask

  // receiver: random gaps per word, one long hold-off on request
  initial begin
    int gap;
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = draw_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // watchdog: ends the run when no word moves for too long
  initial begin
    int stall;
    stall = 0;
    while (stall < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall = 0;
      else stall++;
    end
    $display("FAIL frame_deframer_xor_checksum_core");
    $finish;
  end

  initial begin
    int start;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed frames under the reset codes
    send_byte(8'hFF);                      // dropped while hunting
    frame_q = {c_int8, 8'h00};             // int8, lowest payload
    send_frame_q(1'b1, 1'b0);
    frame_q = {c_int8, 8'hFF};             // int8, highest payload
    send_frame_q(1'b1, 1'b0);
    frame_q = {c_ack};                     // ack, no payload
    send_frame_q(1'b1, 1'b0);
    frame_q = {c_nack};                    // nack with a bad checksum
    send_frame_q(1'b1, 1'b1);
    frame_q = {8'hFF};                     // unknown command
    send_frame_q(1'b0, 1'b0);
    frame_q = {c_string, 8'h00};           // string of length zero
    send_frame_q(1'b1, 1'b0);
    frame_q = {c_string, 8'h01, hdr};      // header byte inside a frame
    send_frame_q(1'b1, 1'b0);

    // random frames under several code settings
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        0: apply_config(8'd170, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5);
        1: apply_config(8'd0, 8'd255, 8'd128, 8'd127, 8'd0, 8'd254);
        // every code equal: int8 wins
        2: apply_config(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        3: begin
          // twist shares its code with string, ack and nack
          apply_config(8'($urandom), 8'($urandom), 8'hC3, 8'hC3, 8'hC3, 8'hC3);
        end
        // string shares its code with ack and nack
        4: apply_config(8'($urandom), 8'($urandom), 8'($urandom),
                        8'h5A, 8'h5A, 8'h5A);
        default: apply_config(8'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom), 8'h77, 8'h77);
      endcase
      // stall the receiver while the sender keeps offering
      if (ph == 1) hold_req = 1'b1;
      start = sent_count;
      while (sent_count - start < PHASE_BYTES) send_random_frame();
    end

    no_idle = 1'b0;
    wait_idle();
    if (fail_count == 0 && due_count == 0) begin
      $display("PASS frame_deframer_xor_checksum_core");
    end else begin
      $display("FAIL frame_deframer_xor_checksum_core");
    end
    $finish;
  end

endmodule
